### rtl/three_wire_handshake_packet_receiver_top_assert.svh
// assertion macros for the three-wire packet receiver
`ifndef THREE_WIRE_HANDSHAKE_PACKET_RECEIVER_TOP_ASSERT_SVH
`define THREE_WIRE_HANDSHAKE_PACKET_RECEIVER_TOP_ASSERT_SVH
// a property that must hold whenever reset is not active
`define TW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// a signal that must never be x or z once reset is released
`define TW_ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`endif

### rtl/twr_pkg.sv
// shared types and constants for the three-wire packet receiver
package twr_pkg;
    localparam int MAX_DATA_BYTES_DEF = 64;
    localparam logic [7:0] LABEL_MULTI = 8'hff;
    localparam logic [7:0] MULTI_LO = 8'h1f;
    localparam logic [7:0] MULTI_HI = 8'h40;
    localparam logic [7:0] MULTI_BASE = 8'h20;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_LABEL = 2'd0;
    localparam logic [1:0] KIND_LEN = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [1:0] ERR_REQ = 2'd0;
    localparam logic [1:0] ERR_BIT = 2'd1;
    localparam logic [1:0] ERR_ACK = 2'd2;

    typedef enum logic [14:0] {
        PH_IDLE         = 15'h0001,
        PH_REQ_LOW      = 15'h0002,
        PH_REQ_HIGH     = 15'h0004,
        PH_LABEL_LOW    = 15'h0008,
        PH_LABEL_HIGH   = 15'h0010,
        PH_LEN_LOW      = 15'h0020,
        PH_LEN_HIGH     = 15'h0040,
        PH_DATA_LOW     = 15'h0080,
        PH_DATA_HIGH    = 15'h0100,
        PH_DUMMY_LOW    = 15'h0200,
        PH_DUMMY_HIGH   = 15'h0400,
        PH_ACKBIT_READY = 15'h0800,
        PH_ACKBIT_TAKEN = 15'h1000,
        PH_PAR_READY    = 15'h2000,
        PH_PAR_TAKEN    = 15'h4000
    } t_phase;

    typedef struct packed {
        logic       enable;
        logic [7:0] debounce;
        logic [15:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic       drive_data_low;
        logic       drive_ack_low;
        logic       drive_clock_low;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [1:0] byte_kind;
        logic       packet_last;
        logic       error_valid;
        logic [1:0] error_code;
    } t_result;
endpackage

### rtl/twr_cfg_regs.sv
// configuration register file
module twr_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output twr_pkg::t_cfg o_cfg
);
    import twr_pkg::*;
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.debounce <= 8'd3;
            r_cfg.timeout  <= 16'd20000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE:   r_cfg.enable <= i_cfg_data[0];
                CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_data[7:0];
                CFG_TIMEOUT:  r_cfg.timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

### rtl/twr_engine.sv
// receive state machine: one line sample per step
module twr_engine #(
    parameter int MAX_DATA_BYTES = twr_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [2:0]       i_levels,
    input  twr_pkg::t_cfg    i_cfg,
    output twr_pkg::t_result o_res
);
    import twr_pkg::*;
    localparam logic [7:0] MAX_LEN = 8'(MAX_DATA_BYTES);

    t_phase r_phase, n_phase;
    logic [15:0] r_wait, n_wait;
    logic [7:0] r_match, n_match, r_shift, n_shift, r_bidx, n_bidx;
    logic [7:0] r_len, n_len, r_label, n_label;
    logic [2:0] r_bit, n_bit;
    logic r_par, n_par, r_multi, n_multi;
    logic [4:0] r_left, n_left;

    logic dat, ack, clk, smp, want, w_ok, w_to, is_wait;
    logic [7:0] m_inc, bval;
    logic [15:0] t_inc;
    t_result res;

    assign dat = i_levels[0];
    assign ack = i_levels[1];
    assign clk = i_levels[2];

    always_comb begin
        is_wait = 1'b1;
        smp = clk;
        want = 1'b0;
        case (r_phase)
            PH_IDLE: is_wait = 1'b0;
            PH_REQ_HIGH, PH_LABEL_HIGH, PH_LEN_HIGH, PH_DATA_HIGH, PH_DUMMY_HIGH:
                want = 1'b1;
            PH_ACKBIT_READY, PH_PAR_READY: begin
                smp = ack;
                want = 1'b1;
            end
            PH_ACKBIT_TAKEN, PH_PAR_TAKEN: smp = ack;
            default: ;
        endcase
        w_ok = is_wait && (smp == want) && (r_match >= i_cfg.debounce);
        m_inc = (smp == want) ? ((r_match != 8'hff) ? r_match + 8'd1 : r_match) : 8'd0;
        t_inc = (r_wait != 16'hffff) ? r_wait + 16'd1 : r_wait;
        w_to = is_wait && !w_ok && (t_inc >= i_cfg.timeout);
    end

    always_comb begin
        logic end_pkt;
        logic [7:0] nb;
        end_pkt = 1'b0;
        n_phase = r_phase; n_wait = r_wait; n_match = r_match; n_shift = r_shift;
        n_bidx = r_bidx; n_len = r_len; n_label = r_label; n_bit = r_bit;
        n_par = r_par; n_multi = r_multi; n_left = r_left;
        res = '0;
        bval = r_shift;
        nb = 8'(r_bidx + 8'd1);
        if (is_wait && !w_ok) begin
            n_match = m_inc;
            n_wait = t_inc;
        end
        if (w_ok) begin
            n_wait = '0;
            n_match = '0;
        end
        case (r_phase)
            PH_IDLE: if (i_cfg.enable && !dat) begin
                n_left = '0; n_multi = 1'b0; n_par = 1'b0; n_shift = '0;
                n_bit = '0; n_bidx = '0; n_phase = PH_REQ_LOW;
                n_wait = '0; n_match = '0;
            end
            PH_REQ_LOW: if (w_ok) n_phase = PH_REQ_HIGH;
            PH_LABEL_LOW, PH_LEN_LOW, PH_DATA_LOW: if (w_ok) begin
                n_shift = r_shift | (8'(dat) << r_bit);
                n_phase = t_phase'(r_phase << 1);
            end
            PH_DUMMY_LOW: if (w_ok) begin
                n_shift = {7'd0, dat};
                n_phase = PH_DUMMY_HIGH;
            end
            PH_REQ_HIGH: if (w_ok) begin
                n_shift = '0; n_bit = '0; n_phase = PH_LABEL_LOW;
            end
            PH_DUMMY_HIGH: if (w_ok) begin
                n_par = r_par ^ r_shift[0]; n_shift = '0; n_phase = PH_ACKBIT_READY;
            end
            PH_LABEL_HIGH, PH_LEN_HIGH, PH_DATA_HIGH: if (w_ok) begin
                n_par = r_par ^ r_shift[r_bit];
                if (r_bit != 3'd7) begin
                    n_bit = r_bit + 3'd1;
                    n_phase = t_phase'(r_phase >> 1);
                end else begin
                    n_bit = '0; n_shift = '0;
                    res.byte_valid = 1'b1;
                    if (r_phase == PH_LABEL_HIGH) begin
                        n_label = r_shift; res.byte_kind = KIND_LABEL;
                        n_phase = PH_LEN_LOW;
                    end else if (r_phase == PH_LEN_HIGH) begin
                        bval = (r_shift > MAX_LEN) ? MAX_LEN : r_shift;
                        n_len = bval; n_bidx = '0; res.byte_kind = KIND_LEN;
                        if (bval == 8'd0) end_pkt = 1'b1;
                        else n_phase = PH_DATA_LOW;
                    end else begin
                        res.byte_kind = KIND_DATA;
                        if (!r_multi && r_bidx == 8'd0 && r_label == LABEL_MULTI &&
                            r_shift > MULTI_LO && r_shift < MULTI_HI)
                            n_left = 5'(r_shift - MULTI_BASE);
                        n_phase = PH_DUMMY_LOW;
                    end
                    res.byte_value = bval;
                end
            end
            PH_ACKBIT_READY: if (w_ok) n_phase = PH_ACKBIT_TAKEN;
            PH_PAR_READY: if (w_ok) n_phase = PH_PAR_TAKEN;
            PH_ACKBIT_TAKEN: if (w_ok) begin
                n_par = ~r_par; n_phase = PH_PAR_READY;
            end
            PH_PAR_TAKEN: if (w_ok) begin
                n_par = 1'b0; n_bidx = nb;
                if (nb >= r_len) end_pkt = 1'b1;
                else n_phase = PH_DATA_LOW;
            end
            default: n_phase = PH_IDLE;
        endcase
        if (w_to) begin
            res.error_valid = 1'b1;
            if (r_phase == PH_REQ_LOW || r_phase == PH_REQ_HIGH) begin
                res.error_code = ERR_REQ;
                n_phase = PH_IDLE; n_multi = 1'b0; n_left = '0;
                res.packet_last = 1'b1;
            end else begin
                res.error_code = (r_phase >= PH_DUMMY_LOW) ? ERR_ACK : ERR_BIT;
                end_pkt = 1'b1;
            end
        end
        // end of packet: next announced packet or end of transfer
        if (end_pkt) begin
            n_par = 1'b0; n_shift = '0; n_bit = '0; n_bidx = '0;
            if (n_left != 5'd0) begin
                n_left = n_left - 5'd1; n_multi = 1'b1;
                n_phase = PH_LABEL_LOW; n_wait = '0; n_match = '0;
            end else begin
                n_phase = PH_IDLE; n_multi = 1'b0; res.packet_last = 1'b1;
            end
        end
        res.drive_ack_low = (n_phase == PH_REQ_LOW) || (n_phase == PH_LABEL_LOW) ||
            (n_phase == PH_LEN_LOW) || (n_phase == PH_DATA_LOW) || (n_phase == PH_DUMMY_LOW);
        res.drive_clock_low = (n_phase == PH_ACKBIT_TAKEN) || (n_phase == PH_PAR_TAKEN);
        res.drive_data_low = (n_phase == PH_PAR_TAKEN) && !n_par;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_wait <= '0; r_match <= '0; r_shift <= '0;
            r_bidx <= '0; r_len <= '0; r_label <= '0; r_bit <= '0;
            r_par <= 1'b0; r_multi <= 1'b0; r_left <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_wait <= n_wait; r_match <= n_match; r_shift <= n_shift;
            r_bidx <= n_bidx; r_len <= n_len; r_label <= n_label; r_bit <= n_bit;
            r_par <= n_par; r_multi <= n_multi; r_left <= n_left;
        end
    end

    assign o_res = res;
endmodule

### rtl/three_wire_handshake_packet_receiver_top.sv
// top level of the three-wire packet receiver
//  channel | direction | tdata (low bit up)                  | tuser
//  s_axis  | in        | data, ack, clock levels             | -
//  m_axis  | out       | drives d/a/c, byte_valid, value,    | -
//          |           | kind, error_valid, error_code       | tlast=packet_last
//  cfg     | in        | enable, debounce_count, timeout     | -
// one request a cycle while the output is not stalled: the state machine steps in the
// accept cycle and the result lands in a one-deep output register, shown the next cycle
// input is taken while the output register is empty or is drained this cycle
// synchronous active-low reset puts the machine in idle and config at defaults
module three_wire_handshake_packet_receiver_top #(
    parameter int MAX_DATA_BYTES = twr_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_level, ack_level, clock_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // drive_data_low, drive_ack_low, drive_clock_low, byte_valid,
    // byte_value[7:0], byte_kind[1:0], error_valid, error_code[1:0]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,   // packet_last
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import twr_pkg::*;
    `include "three_wire_handshake_packet_receiver_top_assert.svh"

    t_cfg    cfg;
    t_result res, r_out;
    logic    r_valid, step;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step = s_axis_tvalid && s_axis_tready;

    twr_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cfg(cfg)
    );

    twr_engine #(.MAX_DATA_BYTES(MAX_DATA_BYTES)) u_eng (
        .i_clk, .i_rst_n, .i_step(step), .i_levels(s_axis_tdata[2:0]),
        .i_cfg(cfg), .o_res(res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (step) r_out <= res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = r_out.packet_last;
    assign m_axis_tdata  = {7'd0, r_out.error_code, r_out.error_valid, r_out.byte_kind,
                            r_out.byte_value, r_out.byte_valid, r_out.drive_clock_low,
                            r_out.drive_ack_low, r_out.drive_data_low};

    `TW_ASSERT(a_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped while stalled")
    `TW_ASSERT(a_nobyte, i_clk, i_rst_n, (m_axis_tvalid && !r_out.byte_valid) |-> (r_out.byte_value == 8'd0), "byte value without byte")
    `TW_ASSERT(a_excl, i_clk, i_rst_n, m_axis_tvalid |-> !(r_out.byte_valid && r_out.error_valid), "byte and error together")
    `TW_ASSERT_KNOWN(a_known, i_clk, i_rst_n, m_axis_tvalid, "result valid unknown")
endmodule
